// ----- rtl/core/iiea_pkg.sv -----
// Shared codes and fixed field widths for the indexed insert/erase array.
// No dependencies; the top level takes names from here.
`timescale 1ns / 1ps

package iiea_pkg;

    localparam int FUNC_W = 2;
    localparam int IDX_W  = 7;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ERASE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

endpackage

// ----- rtl/core/iiea_mem.sv -----
// Element RAM: one write port, one read port, read data registered.
// Depends on nothing; sized by the top level's parameters.
`timescale 1ns / 1ps

module iiea_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/indexed_insert_erase_array.sv -----
// Top level of the indexed insert/erase array: sequencer, count and result register.
// Depends on iiea_pkg (codes, widths) and iiea_mem (element RAM).
`timescale 1ns / 1ps

//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------------
//  in      | input     | in_valid / in_stall   | func, index, value
//  out     | output    | out_valid / out_stall | read_value, status, count, is_empty
//
//  One item is worked on at a time; in_stall is high while the sequencer is busy.
//  Path per item, with n elements held and index i (all end in S_FIN):
//    clear, refused request, append, erase of the last element: no other state
//    read: S_RDWAIT;  mid insert: n-i moves up, S_PUT;  mid erase: n-i-1 moves down
//  The element moves run through the single RAM read/write port pair, one per cycle.
//  Reset clears the count and the control state; the RAM needs no clearing pass.
//  A result waiting on out_stall holds only the next item's finish, not its accept.

module indexed_insert_erase_array #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [iiea_pkg::FUNC_W-1:0]    func,
    input  logic [iiea_pkg::IDX_W-1:0]     index,
    input  logic [iiea_pkg::DATA_W-1:0]    value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [iiea_pkg::DATA_W-1:0]    read_value,
    output logic [iiea_pkg::STAT_W-1:0]    status,
    output logic [iiea_pkg::CNT_W-1:0]     count,
    output logic                           is_empty
);

    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);
    localparam int CMP_W = (NW > iiea_pkg::IDX_W) ? NW : iiea_pkg::IDX_W;

    localparam logic [NW-1:0] DEPTH_N = NW'(DEPTH);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UP     = 3'd1;
    localparam logic [2:0] S_PUT    = 3'd2;
    localparam logic [2:0] S_DOWN   = 3'd3;
    localparam logic [2:0] S_RDWAIT = 3'd4;
    localparam logic [2:0] S_FIN    = 3'd5;

    logic [2:0]                    state_reg, state_next;
    logic [NW-1:0]                 cnt_reg, cnt_next;
    logic [AW-1:0]                 ptr_reg, ptr_next;
    logic [AW-1:0]                 idx_reg, idx_next;
    logic [WIDTH-1:0]              val_reg, val_next;
    logic [WIDTH-1:0]              res_rd_reg, res_rd_next;
    logic [iiea_pkg::STAT_W-1:0]   res_st_reg, res_st_next;

    logic                          out_valid_reg, out_valid_next;
    logic [iiea_pkg::DATA_W-1:0]   out_rd_reg, out_rd_next;
    logic [iiea_pkg::STAT_W-1:0]   out_st_reg, out_st_next;
    logic [NW-1:0]                 out_cnt_reg, out_cnt_next;

    logic                          accept;
    logic                          out_free;
    logic [CMP_W-1:0]              idx_ext;
    logic [CMP_W-1:0]              cnt_ext;

    logic                          wr_en;
    logic [AW-1:0]                 wr_addr;
    logic [WIDTH-1:0]              wr_data;
    logic [AW-1:0]                 rd_addr;
    logic [WIDTH-1:0]              rd_data;

    iiea_mem #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH),
        .AW    (AW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign idx_ext  = CMP_W'(index);
    assign cnt_ext  = CMP_W'(cnt_reg);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        ptr_next    = ptr_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        res_rd_next = res_rd_reg;
        res_st_next = res_st_reg;
        wr_en       = 1'b0;
        wr_addr     = ptr_reg;
        wr_data     = rd_data;
        rd_addr     = ptr_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    // Decide the request against the current count right at accept.
                    idx_next    = AW'(index);
                    val_next    = WIDTH'(value);
                    res_rd_next = '0;
                    res_st_next = iiea_pkg::STAT_DONE;
                    state_next  = S_FIN;
                    case (func)
                        iiea_pkg::FUNC_INSERT:
                        begin
                            if (idx_ext > cnt_ext)
                            begin
                                res_st_next = iiea_pkg::STAT_RANGE;
                            end
                            else if (cnt_reg == DEPTH_N)
                            begin
                                res_st_next = iiea_pkg::STAT_FULL;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 1'b1;
                                if (idx_ext == cnt_ext)
                                begin
                                    // Append: no elements move.
                                    wr_en   = 1'b1;
                                    wr_addr = AW'(index);
                                    wr_data = WIDTH'(value);
                                end
                                else
                                begin
                                    // Start the upward move at the last element.
                                    rd_addr    = AW'(cnt_reg - 1'b1);
                                    ptr_next   = AW'(cnt_reg - 1'b1);
                                    state_next = S_UP;
                                end
                            end
                        end
                        iiea_pkg::FUNC_ERASE:
                        begin
                            if (idx_ext >= cnt_ext)
                            begin
                                res_st_next = iiea_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                cnt_next = cnt_reg - 1'b1;
                                if (idx_ext != cnt_ext - 1'b1)
                                begin
                                    // Start the downward move just above the hole.
                                    rd_addr    = AW'(index) + 1'b1;
                                    ptr_next   = AW'(index) + 1'b1;
                                    state_next = S_DOWN;
                                end
                            end
                        end
                        iiea_pkg::FUNC_READ:
                        begin
                            if (idx_ext >= cnt_ext)
                            begin
                                res_st_next = iiea_pkg::STAT_RANGE;
                            end
                            else
                            begin
                                rd_addr    = AW'(index);
                                state_next = S_RDWAIT;
                            end
                        end
                        default:
                        begin
                            cnt_next = '0;
                        end
                    endcase
                end
            end
            S_UP:
            begin
                // ptr holds the entry read last cycle; copy it one place up.
                wr_en   = 1'b1;
                wr_addr = ptr_reg + 1'b1;
                wr_data = rd_data;
                if (ptr_reg == idx_reg)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    rd_addr  = ptr_reg - 1'b1;
                    ptr_next = ptr_reg - 1'b1;
                end
            end
            S_PUT:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = val_reg;
                state_next = S_FIN;
            end
            S_DOWN:
            begin
                // ptr holds the entry read last cycle; copy it one place down.
                wr_en   = 1'b1;
                wr_addr = ptr_reg - 1'b1;
                wr_data = rd_data;
                if (NW'(ptr_reg) == cnt_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    rd_addr  = ptr_reg + 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_RDWAIT:
            begin
                res_rd_next = rd_data;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                // Hold here until the output register can take the result.
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_rd_next    = out_rd_reg;
        out_st_next    = out_st_reg;
        out_cnt_next   = out_cnt_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_FIN) && out_free)
        begin
            out_valid_next = 1'b1;
            out_rd_next    = iiea_pkg::DATA_W'(res_rd_reg);
            out_st_next    = res_st_reg;
            out_cnt_next   = cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg     <= ptr_next;
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        res_rd_reg  <= res_rd_next;
        res_st_reg  <= res_st_next;
        out_rd_reg  <= out_rd_next;
        out_st_reg  <= out_st_next;
        out_cnt_reg <= out_cnt_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = out_rd_reg;
    assign status     = out_st_reg;
    assign count      = iiea_pkg::CNT_W'(out_cnt_reg);
    assign is_empty   = (out_cnt_reg == '0);

endmodule
